>>> rtl/cpib_pkg.sv
// shared types, constants and a pointer helper for the cpu io port and interrupt bridge
package cpib_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CMD_MAINLOOP = 8'hB9;
  localparam logic [7:0] CMD_TIMER = 8'h86;
  localparam logic [7:0] CMD_BUTTON = 8'h83;
  localparam logic [7:0] ROM_PORT = 8'h0A;
  localparam logic [7:0] IDLE_BUS = 8'hFF;
  localparam logic [7:0] VECTOR_RESET = 8'h04;

  localparam logic [1:0] MODE_TIMER = 2'd0;
  localparam logic [1:0] MODE_MAINLOOP = 2'd1;
  localparam logic [1:0] MODE_BUTTON = 2'd2;

  typedef struct packed {
    logic        host_valid;
    logic [7:0]  host_byte;
    logic        io_request;
    logic        read_strobe;
    logic        write_strobe;
    logic        fetch_cycle;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } in_item_t;

  typedef struct packed {
    logic       interrupt_asserted;
    logic       drive_bus;
    logic [7:0] drive_value;
    logic       hold_cpu;
    logic       write_valid;
    logic [7:0] write_port;
    logic [7:0] write_value;
    logic [1:0] clock_select;
  } out_item_t;

  typedef struct packed {
    logic       push_req;
    logic [7:0] push_data;
    logic       pop_req;
  } q_req_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

>>> rtl/cpib_queue.sv
// byte fifo in a synchronous memory with push-to-pop forwarding
module cpib_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  cpib_pkg::q_req_t req,
  output logic            pop_ok,
  output logic [7:0]      rd_data
);

  logic [7:0] mem [cpib_pkg::QUEUE_DEPTH];
  logic [cpib_pkg::PTR_W-1:0] head_r, head_nxt;
  logic [cpib_pkg::PTR_W-1:0] tail_r, tail_nxt;
  logic [7:0] rd_q_r;
  logic       fwd_r;
  logic [7:0] fwd_data_r;
  logic       empty, full, push_ok;

  assign empty = (head_r == tail_r);
  assign full = (cpib_pkg::ptr_inc(tail_r) == head_r);
  assign push_ok = req.push_req && !full;
  assign pop_ok = req.pop_req && (!empty || push_ok);

  always_comb begin
    tail_nxt = push_ok ? cpib_pkg::ptr_inc(tail_r) : tail_r;
    head_nxt = pop_ok ? cpib_pkg::ptr_inc(head_r) : head_r;
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail_r] <= req.push_data;
    end
    rd_q_r <= mem[head_r];
    fwd_data_r <= req.push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fwd_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fwd_r <= empty;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;

endmodule

>>> rtl/cpu_io_port_and_interrupt_bridge_unit.sv
// top level of the cpu io port and interrupt bridge
// One sampling tick is taken per start transfer: the tick is accepted from idle, the
// exec state updates the fifo pointers and issues the memory reads, and in the out state
// the memory read data settles the result, which stands on out_item for that cycle with
// out_valid high. busy is high from the accepting edge until the result cycle ends. The
// receiver cannot stall. The receive and vector fifos each sit in a single-port-write,
// registered-read memory; a byte pushed and popped in the same tick is forwarded.
module cpu_io_port_and_interrupt_bridge_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cpib_pkg::in_item_t  in_item,
  output logic                out_valid,
  output cpib_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  logic [1:0] state_r, state_nxt;
  cpib_pkg::in_item_t item_r;
  logic [7:0] receive_vector_r;
  logic [7:0] pending_vector_r, pending_vector_nxt;
  logic       int_pending_r, int_pending_nxt;
  logic       served_r, served_nxt;
  logic       driven_r, driven_nxt;
  logic [7:0] held_r, held_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       rd_srv_r, rd_srv_nxt;
  logic       ack_srv_r, ack_srv_nxt;
  logic       wr_srv_r, wr_srv_nxt;
  logic       rx_pop_r, vec_pop_r;

  cpib_pkg::q_req_t rx_req, vec_req;
  logic       rx_pop_ok, vec_pop_ok;
  logic [7:0] rx_data, vec_data;
  logic       exec, open_cycle, push_data;
  logic [7:0] vec_val;

  cpib_queue u_rx_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (rx_req),
    .pop_ok  (rx_pop_ok),
    .rd_data (rx_data)
  );

  cpib_queue u_vec_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (vec_req),
    .pop_ok  (vec_pop_ok),
    .rd_data (vec_data)
  );

  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign exec = (state_r == ST_EXEC);
  assign open_cycle = item_r.io_request && !served_r;
  assign push_data = exec && item_r.host_valid && !item_r.host_byte[7];

  always_comb begin
    rx_req.push_req = push_data;
    rx_req.push_data = item_r.host_byte;
    rx_req.pop_req = exec && open_cycle && item_r.read_strobe
                     && (item_r.bus_address[7:0] != cpib_pkg::ROM_PORT);
    vec_req.push_req = push_data;
    vec_req.push_data = receive_vector_r;
    vec_req.pop_req = exec && !int_pending_r;
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt = mode_r;
    int_pending_nxt = int_pending_r;
    served_nxt = served_r;
    driven_nxt = driven_r;
    rd_srv_nxt = rd_srv_r;
    ack_srv_nxt = ack_srv_r;
    wr_srv_nxt = wr_srv_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_OUT;
        rd_srv_nxt = 1'b0;
        ack_srv_nxt = 1'b0;
        wr_srv_nxt = 1'b0;
        if (item_r.host_valid && item_r.host_byte[7]) begin
          case (item_r.host_byte)
            cpib_pkg::CMD_MAINLOOP: mode_nxt = cpib_pkg::MODE_MAINLOOP;
            cpib_pkg::CMD_TIMER:    mode_nxt = cpib_pkg::MODE_TIMER;
            cpib_pkg::CMD_BUTTON:   mode_nxt = cpib_pkg::MODE_BUTTON;
            default:                mode_nxt = mode_r;
          endcase
        end
        if (vec_pop_ok) begin
          int_pending_nxt = 1'b1;
        end
        if (item_r.io_request) begin
          if (!served_r) begin
            if (item_r.read_strobe) begin
              rd_srv_nxt = 1'b1;
              driven_nxt = 1'b1;
              served_nxt = 1'b1;
            end else if (item_r.write_strobe) begin
              wr_srv_nxt = 1'b1;
              served_nxt = 1'b1;
            end else if (item_r.fetch_cycle) begin
              ack_srv_nxt = 1'b1;
              driven_nxt = 1'b1;
              served_nxt = 1'b1;
              int_pending_nxt = 1'b0;
            end
          end
        end else begin
          driven_nxt = 1'b0;
          served_nxt = 1'b0;
        end
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // memory read data resolves the popped bytes in the result cycle
  always_comb begin
    vec_val = vec_pop_r ? vec_data : pending_vector_r;
    pending_vector_nxt = pending_vector_r;
    held_nxt = held_r;
    if (state_r == ST_OUT) begin
      pending_vector_nxt = vec_val;
      if (rd_srv_r) begin
        held_nxt = rx_pop_r ? rx_data : cpib_pkg::IDLE_BUS;
      end else if (ack_srv_r) begin
        held_nxt = vec_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      receive_vector_r <= cpib_pkg::VECTOR_RESET;
      pending_vector_r <= '0;
      int_pending_r <= 1'b0;
      served_r <= 1'b0;
      driven_r <= 1'b0;
      held_r <= cpib_pkg::IDLE_BUS;
      mode_r <= cpib_pkg::MODE_MAINLOOP;
      rd_srv_r <= 1'b0;
      ack_srv_r <= 1'b0;
      wr_srv_r <= 1'b0;
      rx_pop_r <= 1'b0;
      vec_pop_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        receive_vector_r <= cfg_data;
      end
      pending_vector_r <= pending_vector_nxt;
      int_pending_r <= int_pending_nxt;
      served_r <= served_nxt;
      driven_r <= driven_nxt;
      held_r <= held_nxt;
      mode_r <= mode_nxt;
      rd_srv_r <= rd_srv_nxt;
      ack_srv_r <= ack_srv_nxt;
      wr_srv_r <= wr_srv_nxt;
      if (exec) begin
        rx_pop_r <= rx_pop_ok;
        vec_pop_r <= vec_pop_ok;
      end
    end
  end

  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    out_item.interrupt_asserted = int_pending_r;
    out_item.drive_bus = driven_r;
    out_item.drive_value = driven_r ? held_nxt : 8'h00;
    out_item.hold_cpu = item_r.io_request;
    out_item.write_valid = wr_srv_r;
    out_item.write_port = wr_srv_r ? item_r.bus_address[7:0] : 8'h00;
    out_item.write_value = wr_srv_r ? item_r.bus_data : 8'h00;
    out_item.clock_select = mode_r;
  end

endmodule

>>> tb/sv/cpu_io_port_and_interrupt_bridge_unit_tb.sv
// self-checking testbench for the cpu io port and interrupt bridge unit
module cpu_io_port_and_interrupt_bridge_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int IN_W = $bits(cpib_pkg::in_item_t);

  typedef enum logic [1:0] {CYC_READ, CYC_WRITE, CYC_ACK, CYC_BARE} bus_cycle_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  cpib_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  cpib_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_data = '0;

  cpib_pkg::in_item_t  tick_queue[$];
  cpib_pkg::out_item_t expected_ticks[$];
  cpib_pkg::out_item_t want;
  int          items_queued = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          gap_left = 0;
  int          idle_cycles = 0;
  int          vector_writes = 0;
  bit          steady = 1'b0;

  // bridge state as predicted
  logic [7:0]  rx_vector = cpib_pkg::VECTOR_RESET;
  logic [7:0]  rx_fifo[$];
  logic [7:0]  vec_fifo[$];
  logic [7:0]  irq_vector = '0;
  logic        irq_pending = 1'b0;
  logic        cycle_done = 1'b0;
  logic        driving = 1'b0;
  logic [7:0]  held = cpib_pkg::IDLE_BUS;
  logic [1:0]  mode_q = cpib_pkg::MODE_MAINLOOP;
  int          rx_drops = 0;
  int          served_reads = 0;
  int          served_writes = 0;
  int          served_acks = 0;

  cpu_io_port_and_interrupt_bridge_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic cpib_pkg::out_item_t bridge_tick(input cpib_pkg::in_item_t it);
    cpib_pkg::out_item_t r;
    logic [7:0]          port;
    r = '0;
    port = it.bus_address[7:0];
    if (it.host_valid) begin
      if (it.host_byte[7]) begin
        case (it.host_byte)
          cpib_pkg::CMD_MAINLOOP: mode_q = cpib_pkg::MODE_MAINLOOP;
          cpib_pkg::CMD_TIMER:    mode_q = cpib_pkg::MODE_TIMER;
          cpib_pkg::CMD_BUTTON:   mode_q = cpib_pkg::MODE_BUTTON;
          default: ;
        endcase
      end else begin
        if (rx_fifo.size() < cpib_pkg::QUEUE_DEPTH - 1) rx_fifo.push_back(it.host_byte);
        else rx_drops++;
        if (vec_fifo.size() < cpib_pkg::QUEUE_DEPTH - 1) vec_fifo.push_back(rx_vector);
      end
    end
    if (!irq_pending && vec_fifo.size() > 0) begin
      irq_vector = vec_fifo.pop_front();
      irq_pending = 1'b1;
    end
    if (it.io_request) begin
      if (!cycle_done) begin
        if (it.read_strobe) begin
          if (port == cpib_pkg::ROM_PORT || rx_fifo.size() == 0) held = cpib_pkg::IDLE_BUS;
          else held = rx_fifo.pop_front();
          driving = 1'b1;
          cycle_done = 1'b1;
          served_reads++;
        end else if (it.write_strobe) begin
          r.write_valid = 1'b1;
          r.write_port = port;
          r.write_value = it.bus_data;
          cycle_done = 1'b1;
          served_writes++;
        end else if (it.fetch_cycle) begin
          held = irq_vector;
          driving = 1'b1;
          cycle_done = 1'b1;
          irq_pending = 1'b0;
          served_acks++;
        end
      end
    end else begin
      driving = 1'b0;
      cycle_done = 1'b0;
    end
    r.interrupt_asserted = irq_pending;
    r.drive_bus = driving;
    r.drive_value = driving ? held : 8'h00;
    r.hold_cpu = it.io_request;
    r.clock_select = mode_q;
    return r;
  endfunction

  // driver: one tick per start transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_ticks.push_back(bridge_tick(in_item));
        items_sent++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (!steady && $urandom_range(99) < 7) begin
          gap_left = $urandom_range(0, 3);
          start <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          in_item <= tick_queue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string detail);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t ns: %s", $time, detail);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
    if (got !== exp_v)
      report_mismatch($sformatf("%s expected %h got %h", name, exp_v, got));
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_ticks.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_item));
      end else begin
        want = expected_ticks.pop_front();
        check_field("interrupt_asserted", 8'(out_item.interrupt_asserted),
                    8'(want.interrupt_asserted));
        check_field("drive_bus", 8'(out_item.drive_bus), 8'(want.drive_bus));
        check_field("drive_value", out_item.drive_value, want.drive_value);
        check_field("hold_cpu", 8'(out_item.hold_cpu), 8'(want.hold_cpu));
        check_field("write_valid", 8'(out_item.write_valid), 8'(want.write_valid));
        check_field("write_port", out_item.write_port, want.write_port);
        check_field("write_value", out_item.write_value, want.write_value);
        check_field("clock_select", 8'(out_item.clock_select), 8'(want.clock_select));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_tick(input cpib_pkg::in_item_t it);
    tick_queue.push_back(it);
    items_queued++;
  endtask

  function automatic cpib_pkg::in_item_t make_tick(input int hv, input logic [7:0] hb,
                                                   input int io, input int rd, input int wr,
                                                   input int m1, input logic [15:0] addr,
                                                   input logic [7:0] data);
    cpib_pkg::in_item_t it;
    it.host_valid = 1'(hv);
    it.host_byte = hb;
    it.io_request = 1'(io);
    it.read_strobe = 1'(rd);
    it.write_strobe = 1'(wr);
    it.fetch_cycle = 1'(m1);
    it.bus_address = addr;
    it.bus_data = data;
    return it;
  endfunction

  function automatic cpib_pkg::in_item_t host_part(input int host_pct, input int data_pct);
    cpib_pkg::in_item_t it;
    it = '0;
    it.host_byte = 8'($urandom);
    if ($urandom_range(99) < host_pct) begin
      it.host_valid = 1'b1;
      if ($urandom_range(99) < data_pct) begin
        it.host_byte = 8'($urandom_range(0, 127));
      end else begin
        case ($urandom_range(3))
          0: it.host_byte = cpib_pkg::CMD_MAINLOOP;
          1: it.host_byte = cpib_pkg::CMD_TIMER;
          2: it.host_byte = cpib_pkg::CMD_BUTTON;
          default: it.host_byte = 8'($urandom_range(128, 255));
        endcase
      end
    end
    return it;
  endfunction

  task automatic queue_bus_cycle(input int host_pct, input int data_pct, input int read_bias,
                                 input bit reads_ok, input bit acks_ok);
    bus_cycle_e          kind;
    int                  len;
    int                  strobe_at;
    logic [15:0]         addr;
    logic [7:0]          data;
    cpib_pkg::in_item_t  it;
    if (reads_ok && $urandom_range(99) < read_bias) begin
      kind = CYC_READ;
    end else begin
      do kind = bus_cycle_e'($urandom_range(3));
      while ((kind == CYC_READ && !reads_ok) || (kind == CYC_ACK && !acks_ok));
    end
    len = $urandom_range(1, 4);
    strobe_at = $urandom_range(0, len - 1);
    addr = 16'($urandom);
    if ($urandom_range(99) < 15) addr[7:0] = cpib_pkg::ROM_PORT;
    data = 8'($urandom);
    for (int t = 0; t < len; t++) begin
      it = host_part(host_pct, data_pct);
      it.io_request = 1'b1;
      it.bus_address = addr;
      it.bus_data = data;
      if (t >= strobe_at) begin
        case (kind)
          CYC_READ: begin
            it.read_strobe = 1'b1;
            it.write_strobe = 1'($urandom_range(1));
            it.fetch_cycle = 1'($urandom_range(1));
          end
          CYC_WRITE: begin
            it.write_strobe = 1'b1;
            it.fetch_cycle = 1'($urandom_range(1));
          end
          CYC_ACK: it.fetch_cycle = 1'b1;
          default: ;
        endcase
      end
      queue_tick(it);
    end
    repeat ($urandom_range(1, 2)) begin
      it = host_part(host_pct, data_pct);
      it.bus_address = 16'($urandom);
      it.bus_data = 8'($urandom);
      queue_tick(it);
    end
  endtask

  task automatic queue_phase(input int n, input int host_pct, input int data_pct,
                             input int read_bias, input bit reads_ok, input bit acks_ok);
    int                  first;
    logic [IN_W-1:0]     raw;
    cpib_pkg::in_item_t  it;
    first = items_queued;
    while (items_queued - first < n) begin
      if ($urandom_range(99) < 10) begin
        raw = IN_W'({$urandom, $urandom});
        it = raw;
        if (!reads_ok) it.read_strobe = 1'b0;
        if (!acks_ok) it.fetch_cycle = 1'b0;
        queue_tick(it);
      end else begin
        queue_bus_cycle(host_pct, data_pct, read_bias, reads_ok, acks_ok);
      end
    end
  endtask

  task automatic wait_idle();
    while (tick_queue.size() > 0 || start || busy || expected_ticks.size() > 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_vector(input logic [7:0] v);
    repeat ($urandom_range(1, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rx_vector = v;
    vector_writes++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    queue_tick(make_tick(0, 8'h00, 1, 1, 0, 0, 16'h0000, 8'h00));
    queue_tick(make_tick(0, 8'h00, 0, 0, 0, 0, 16'h0000, 8'h00));
    queue_tick(make_tick(1, cpib_pkg::CMD_TIMER, 0, 0, 0, 0, 16'h0000, 8'h00));
    queue_tick(make_tick(1, cpib_pkg::CMD_BUTTON, 0, 0, 0, 0, 16'h0000, 8'h00));
    queue_tick(make_tick(1, 8'hFF, 0, 0, 0, 0, 16'h0000, 8'h00));
    queue_tick(make_tick(1, cpib_pkg::CMD_MAINLOOP, 0, 0, 0, 0, 16'h0000, 8'h00));
    queue_tick(make_tick(1, 8'h00, 0, 0, 0, 0, 16'h0000, 8'h00));
    queue_tick(make_tick(1, 8'h7F, 0, 0, 0, 0, 16'h0000, 8'h00));
    queue_tick(make_tick(0, 8'h00, 1, 0, 0, 0, {8'hFF, cpib_pkg::ROM_PORT}, 8'h00));
    queue_tick(make_tick(0, 8'h00, 1, 1, 0, 0, {8'hFF, cpib_pkg::ROM_PORT}, 8'h00));
    queue_tick(make_tick(0, 8'h00, 0, 0, 0, 0, 16'h0000, 8'h00));
    queue_tick(make_tick(0, 8'h00, 1, 1, 1, 1, 16'h12FF, 8'h00));
    queue_tick(make_tick(0, 8'h00, 1, 1, 0, 0, 16'h12FF, 8'h00));
    queue_tick(make_tick(0, 8'h00, 0, 0, 0, 0, 16'h0000, 8'h00));
    queue_tick(make_tick(0, 8'h00, 1, 0, 1, 1, 16'hFFFF, 8'hFF));
    queue_tick(make_tick(0, 8'h00, 1, 0, 1, 0, 16'hFFFF, 8'h00));
    queue_tick(make_tick(0, 8'h00, 0, 0, 0, 0, 16'h0000, 8'h00));
    queue_tick(make_tick(0, 8'h00, 1, 0, 0, 1, 16'h0000, 8'h00));
    queue_tick(make_tick(0, 8'h00, 0, 0, 0, 0, 16'h0000, 8'h00));
    queue_tick(make_tick(0, 8'h00, 1, 0, 0, 1, 16'h0000, 8'h00));
    queue_tick(make_tick(0, 8'h00, 0, 0, 0, 0, 16'h0000, 8'h00));
    queue_tick(make_tick(0, 8'h00, 1, 0, 0, 1, 16'h0000, 8'h00));
    queue_tick(make_tick(0, 8'h00, 0, 1, 1, 1, 16'hFFFF, 8'hFF));
    queue_tick(make_tick(1, 8'h55, 1, 1, 0, 0, 16'h0001, 8'h00));
    queue_tick(make_tick(0, 8'h00, 0, 0, 0, 0, 16'h0000, 8'h00));
    wait_idle();

    write_vector(8'hFF);
    queue_phase(120, 40, 80, 25, 1'b1, 1'b1);
    wait_idle();

    // fill both fifos past capacity, then drain only the vectors
    write_vector(8'h00);
    queue_phase(300, 100, 100, 0, 1'b0, 1'b0);
    queue_phase(25, 100, 100, 0, 1'b0, 1'b1);
    wait_idle();

    write_vector(8'($urandom));
    steady = 1'b1;
    queue_phase(150, 20, 85, 70, 1'b1, 1'b1);
    wait_idle();
    steady = 1'b0;

    write_vector(8'($urandom_range(1, 254)));
    queue_phase(60, 50, 70, 30, 1'b1, 1'b1);
    wait_idle();
    repeat (8) @(posedge clk);

    if (expected_ticks.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", expected_ticks.size()));
    $display("%0d ticks sent, %0d results checked over %0d vector settings",
             items_sent, results_seen, vector_writes + 1);
    $display("bus served %0d reads, %0d writes, %0d acknowledges; %0d host bytes dropped",
             served_reads, served_writes, served_acks, rx_drops);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cpib_pkg.sv
rtl/cpib_queue.sv
rtl/cpu_io_port_and_interrupt_bridge_unit.sv
tb/sv/cpu_io_port_and_interrupt_bridge_unit_tb.sv
